>>> src/quaternion_arith_unit_macros.svh
// assertion helpers
`ifndef QUATERNION_ARITH_UNIT_MACROS_SVH
`define QUATERNION_ARITH_UNIT_MACROS_SVH
`define QAU_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (c)) \
        else $error("qau check failed");
`define QAU_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (c)) \
        else $error("qau check failed");
`endif

>>> src/qau_pkg.sv
package qau_pkg;
    localparam int FRAC_BITS = 13;
    localparam int CORDIC_STEPS = 16;
    localparam int CF_BITS = 30;
    localparam int AW = 34;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [2:0] {
        FN_ADD = 3'd0, FN_SUB = 3'd1, FN_MUL = 3'd2, FN_AXIS = 3'd3, FN_MAT = 3'd4
    } func_t;

    typedef logic signed [15:0] comp_t;

    // cell payload: Hamilton/matrix terms and CORDIC vector
    typedef struct packed {
        logic        vld;
        logic [2:0]  fn;
        comp_t       ax, ay, az, aw;
        comp_t       bx, by, bz, bw;
        logic signed [AW-1:0] cx, cy, th;
    } cell_t;

    function automatic logic signed [AW-1:0] atan_val(input logic [4:0] i);
        logic signed [AW-1:0] t [32];
        t = '{34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
              34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
              34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
              34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430,
              34'sd5215, 34'sd2608, 34'sd1304, 34'sd652, 34'sd326, 34'sd163,
              34'sd81, 34'sd41, 34'sd20, 34'sd10, 34'sd5, 34'sd3, 34'sd1,
              34'sd1, 34'sd0};
        return t[i];
    endfunction

    function automatic comp_t sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) return 16'sh7fff;
        if (v < -64'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int s);
        if (s == 0) return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction
endpackage

>>> src/qau_cell.sv
module qau_cell
    import qau_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic [4:0] step,
    input  cell_t      d,
    output cell_t      q
);
    cell_t q_reg, q_next;
    logic signed [AW-1:0] dx, dy;

    always_comb begin
        q_next = d;
        dx = d.cy >>> step;
        dy = d.cx >>> step;
        if (d.fn == FN_AXIS) begin
            if (d.th >= 0) begin
                q_next.cx = d.cx - dx;
                q_next.cy = d.cy + dy;
                q_next.th = d.th - atan_val(step);
            end else begin
                q_next.cx = d.cx + dx;
                q_next.cy = d.cy - dy;
                q_next.th = d.th + atan_val(step);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= '0;
        end else if (en) begin
            q_reg <= q_next;
        end
    end
    assign q = q_reg;
endmodule

>>> src/qau_finish.sv
module qau_finish
    import qau_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  cell_t d,
    output logic  vld,
    output logic [2:0] fn,
    output logic signed [63:0] p [12]
);
    logic vld_reg;
    logic [2:0] fn_reg;
    logic signed [63:0] p_reg [12];
    logic signed [63:0] p_next [12];
    logic signed [31:0] ax, ay, az, aw, bx, by, bz, bw;

    always_comb begin
        ax = 32'(d.ax); ay = 32'(d.ay); az = 32'(d.az); aw = 32'(d.aw);
        bx = 32'(d.bx); by = 32'(d.by); bz = 32'(d.bz); bw = 32'(d.bw);
        for (int i = 0; i < 12; i++) p_next[i] = '0;
        case (d.fn)
            FN_ADD: begin
                p_next[0] = 64'(ax + bx); p_next[1] = 64'(ay + by);
                p_next[2] = 64'(az + bz); p_next[3] = 64'(aw + bw);
            end
            FN_SUB: begin
                p_next[0] = 64'(ax - bx); p_next[1] = 64'(ay - by);
                p_next[2] = 64'(az - bz); p_next[3] = 64'(aw - bw);
            end
            FN_MUL: begin
                p_next[0] = 64'(aw*bx); p_next[1] = 64'(ax*bw);
                p_next[2] = 64'(ay*bz); p_next[3] = -64'(az*by);
                p_next[4] = 64'(aw*by); p_next[5] = 64'(ay*bw);
                p_next[6] = 64'(az*bx); p_next[7] = -64'(ax*bz);
                p_next[8] = 64'(aw*bz); p_next[9] = 64'(az*bw);
                p_next[10] = 64'(ax*by); p_next[11] = -64'(ay*bx);
            end
            FN_AXIS: begin
                p_next[0] = 64'(ax) * 64'(d.cx); p_next[1] = 64'(ay) * 64'(d.cx);
                p_next[2] = 64'(az) * 64'(d.cx); p_next[3] = -64'(d.cy);
            end
            FN_MAT: begin
                p_next[0] = 64'(ax*ax); p_next[1] = 64'(ay*ay);
                p_next[2] = 64'(az*az); p_next[3] = 64'(ax*ay);
                p_next[4] = 64'(ax*az); p_next[5] = 64'(ay*az);
                p_next[6] = 64'(ax*aw); p_next[7] = 64'(ay*aw);
                p_next[8] = 64'(az*aw);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= d.vld && (d.fn <= FN_MAT);
        end
        if (en) begin
            fn_reg <= d.fn;
            p_reg <= p_next;
        end
    end
    assign vld = vld_reg;
    assign fn = fn_reg;
    assign p = p_reg;
endmodule

>>> src/quaternion_arith_unit.sv
// A request passes through the CORDIC cells, the multiply stage and the output register.
// One request per cycle while results are taken; a to-matrix request gives four result
// rows and holds the chain until its last row is taken.
// The chain is a row of CORDIC_STEPS cells plus one multiply stage.
// Reset (aresetn low, synchronous) empties the chain and output register.
`include "quaternion_arith_unit_macros.svh"
module quaternion_arith_unit
    import qau_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  comp_t       s_a_x, s_a_y, s_a_z, s_a_w,
    input  comp_t       s_b_x, s_b_y, s_b_z, s_b_w,
    input  logic [15:0] s_turn_angle,
    output logic        m_valid,
    input  logic        m_ready,
    output comp_t       m_res_x, m_res_y, m_res_z, m_res_w,
    output logic [1:0]  m_row_index,
    output logic        m_last
);
    cell_t chain [CORDIC_STEPS+1];
    logic en;
    logic f_vld;
    logic [2:0] f_fn;
    logic signed [63:0] p [12];
    logic signed [63:0] pw_reg;
    logic [1:0] row_reg, row_next;
    logic out_vld_reg;
    comp_t rx_reg, ry_reg, rz_reg, rw_reg;
    logic [1:0] ri_reg;
    logic last_reg;
    logic take;
    logic done;
    comp_t rx, ry, rz, rw;
    logic signed [63:0] one2;

    assign take = f_vld && (!out_vld_reg || m_ready);
    assign done = take && (f_fn != FN_MAT || row_reg == 2'd3);
    assign en = !f_vld || done;
    assign s_ready = en;

    always_comb begin
        chain[0].vld = s_valid;
        chain[0].fn = s_func;
        chain[0].ax = s_a_x; chain[0].ay = s_a_y; chain[0].az = s_a_z;
        chain[0].aw = s_a_w;
        chain[0].bx = s_b_x; chain[0].by = s_b_y; chain[0].bz = s_b_z;
        chain[0].bw = s_b_w;
        chain[0].cx = CORDIC_GAIN;
        chain[0].cy = '0;
        chain[0].th = (AW'($signed({1'b0, s_turn_angle})) - AW'(32768)) <<< 15;
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        qau_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en), .step(5'(g)),
            .d(chain[g]), .q(chain[g+1])
        );
    end

    qau_finish u_fin (
        .aclk(aclk), .aresetn(aresetn), .en(en), .d(chain[CORDIC_STEPS]),
        .vld(f_vld), .fn(f_fn), .p(p)
    );

    // w of the Hamilton product
    always_ff @(posedge aclk) begin
        if (en) begin
            pw_reg <= 64'(32'(chain[CORDIC_STEPS].aw) * 32'(chain[CORDIC_STEPS].bw))
                    - 64'(32'(chain[CORDIC_STEPS].ax) * 32'(chain[CORDIC_STEPS].bx))
                    - 64'(32'(chain[CORDIC_STEPS].ay) * 32'(chain[CORDIC_STEPS].by))
                    - 64'(32'(chain[CORDIC_STEPS].az) * 32'(chain[CORDIC_STEPS].bz));
        end
    end

    always_comb begin
        one2 = 64'sd1 <<< (2 * FRAC_BITS);
        rx = '0; ry = '0; rz = '0; rw = '0;
        case (f_fn)
            FN_ADD, FN_SUB: begin
                rx = sat16(p[0]); ry = sat16(p[1]); rz = sat16(p[2]); rw = sat16(p[3]);
            end
            FN_MUL: begin
                rx = sat16(rshr(p[0] + p[1] + p[2] + p[3], FRAC_BITS));
                ry = sat16(rshr(p[4] + p[5] + p[6] + p[7], FRAC_BITS));
                rz = sat16(rshr(p[8] + p[9] + p[10] + p[11], FRAC_BITS));
                rw = sat16(rshr(pw_reg, FRAC_BITS));
            end
            FN_AXIS: begin
                rx = sat16(rshr(p[0], CF_BITS)); ry = sat16(rshr(p[1], CF_BITS));
                rz = sat16(rshr(p[2], CF_BITS));
                rw = sat16(rshr(p[3], CF_BITS - FRAC_BITS));
            end
            FN_MAT: begin
                case (row_reg)
                    2'd0: begin
                        rx = sat16(rshr(one2 - 2 * (p[1] + p[2]), FRAC_BITS));
                        ry = sat16(rshr(2 * (p[3] + p[8]), FRAC_BITS));
                        rz = sat16(rshr(2 * (p[4] - p[7]), FRAC_BITS));
                    end
                    2'd1: begin
                        rx = sat16(rshr(2 * (p[3] - p[8]), FRAC_BITS));
                        ry = sat16(rshr(one2 - 2 * (p[0] + p[2]), FRAC_BITS));
                        rz = sat16(rshr(2 * (p[5] + p[6]), FRAC_BITS));
                    end
                    2'd2: begin
                        rx = sat16(rshr(2 * (p[4] + p[7]), FRAC_BITS));
                        ry = sat16(rshr(2 * (p[5] - p[6]), FRAC_BITS));
                        rz = sat16(rshr(one2 - 2 * (p[0] + p[1]), FRAC_BITS));
                    end
                    default: rw = sat16(64'sd1 <<< FRAC_BITS);
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        row_next = row_reg;
        if (take && f_fn == FN_MAT) row_next = row_reg + 2'd1;
        if (done) row_next = 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
            row_reg <= 2'd0;
        end else begin
            row_reg <= row_next;
            if (take) out_vld_reg <= 1'b1;
            else if (m_ready) out_vld_reg <= 1'b0;
        end
        if (take) begin
            rx_reg <= rx; ry_reg <= ry; rz_reg <= rz;
            rw_reg <= rw;
            ri_reg <= (f_fn == FN_MAT) ? row_reg : 2'd0;
            last_reg <= (f_fn != FN_MAT) || (row_reg == 2'd3);
        end
    end

    assign m_valid = out_vld_reg;
    assign m_res_x = rx_reg;
    assign m_res_y = ry_reg;
    assign m_res_z = rz_reg;
    assign m_res_w = rw_reg;
    assign m_row_index = ri_reg;
    assign m_last = last_reg;

    `QAU_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid)
    `QAU_ASSERT_IMPL(a_last_row, m_valid && m_row_index != 2'd0 && m_row_index != 2'd3, !m_last)
    `QAU_ASSERT_IMPL(a_stall, f_vld && f_fn == FN_MAT && row_reg != 2'd3, !s_ready)
endmodule

>>> tb/sv/tb_quaternion_arith_unit.sv
module tb_quaternion_arith_unit;
    import qau_pkg::*;

    typedef struct {
        comp_t      x, y, z, w;
        logic [1:0] row;
        logic       last;
    } quat_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func = '0;
    comp_t       s_a_x = '0, s_a_y = '0, s_a_z = '0, s_a_w = '0;
    comp_t       s_b_x = '0, s_b_y = '0, s_b_z = '0, s_b_w = '0;
    logic [15:0] s_turn_angle = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    comp_t       m_res_x, m_res_y, m_res_z, m_res_w;
    logic [1:0]  m_row_index;
    logic        m_last;

    quat_row_t   expected_rows[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          out_wait = 0;
    localparam int WATCHDOG = 5000;

    quaternion_arith_unit u_top (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic comp_t clamp16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return -16'sh8000;
        return comp_t'(v);
    endfunction

    function automatic longint round_q(input longint v, input int s);
        if (s == 0) return v;
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint atan_turn(input int i);
        longint t[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
            163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
        return t[i];
    endfunction

    function automatic quat_row_t mk_row(input longint x, y, z, w,
                                         input logic [1:0] row, input logic last);
        quat_row_t r;
        r.x = clamp16(x); r.y = clamp16(y); r.z = clamp16(z); r.w = clamp16(w);
        r.row = row; r.last = last;
        return r;
    endfunction

    task automatic predict_quat(input logic [2:0] fn, input longint ax, ay, az, aw,
                                input longint bx, by, bz, bw, input int ang);
        longint th, cx, cy, dx, dy, one2;
        case (fn)
            FN_ADD: expected_rows.push_back(mk_row(ax + bx, ay + by, az + bz, aw + bw, 0, 1));
            FN_SUB: expected_rows.push_back(mk_row(ax - bx, ay - by, az - bz, aw - bw, 0, 1));
            FN_MUL: expected_rows.push_back(mk_row(
                round_q(aw * bx + ax * bw + ay * bz - az * by, FRAC_BITS),
                round_q(aw * by + ay * bw + az * bx - ax * bz, FRAC_BITS),
                round_q(aw * bz + az * bw + ax * by - ay * bx, FRAC_BITS),
                round_q(aw * bw - ax * bx - ay * by - az * bz, FRAC_BITS), 0, 1));
            FN_AXIS: begin
                th = (longint'(ang) - 32768) * 32768;
                cx = 652032874;
                cy = 0;
                for (int i = 0; i < CORDIC_STEPS; i++) begin
                    dx = cy >>> i;
                    dy = cx >>> i;
                    if (th >= 0) begin
                        cx -= dx; cy += dy; th -= atan_turn(i);
                    end else begin
                        cx += dx; cy -= dy; th += atan_turn(i);
                    end
                end
                expected_rows.push_back(mk_row(round_q(ax * cx, CF_BITS),
                    round_q(ay * cx, CF_BITS), round_q(az * cx, CF_BITS),
                    round_q(-cy, CF_BITS - FRAC_BITS), 0, 1));
            end
            FN_MAT: begin
                one2 = longint'(1) <<< (2 * FRAC_BITS);
                expected_rows.push_back(mk_row(
                    round_q(one2 - 2 * (ay * ay + az * az), FRAC_BITS),
                    round_q(2 * (ax * ay + az * aw), FRAC_BITS),
                    round_q(2 * (ax * az - ay * aw), FRAC_BITS), 0, 0, 0));
                expected_rows.push_back(mk_row(
                    round_q(2 * (ax * ay - az * aw), FRAC_BITS),
                    round_q(one2 - 2 * (ax * ax + az * az), FRAC_BITS),
                    round_q(2 * (ay * az + ax * aw), FRAC_BITS), 0, 1, 0));
                expected_rows.push_back(mk_row(
                    round_q(2 * (ax * az + ay * aw), FRAC_BITS),
                    round_q(2 * (ay * az - ax * aw), FRAC_BITS),
                    round_q(one2 - 2 * (ax * ax + ay * ay), FRAC_BITS), 0, 2, 0));
                expected_rows.push_back(mk_row(0, 0, 0, longint'(1) <<< FRAC_BITS, 3, 1));
            end
            default: ;
        endcase
    endtask

    task automatic send_request(input logic [2:0] fn, input comp_t ax, ay, az, aw,
                                input comp_t bx, by, bz, bw, input logic [15:0] ang);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= fn;
        s_a_x <= ax; s_a_y <= ay; s_a_z <= az; s_a_w <= aw;
        s_b_x <= bx; s_b_y <= by; s_b_z <= bz; s_b_w <= bw;
        s_turn_angle <= ang;
        do @(posedge aclk); while (!s_ready);
        predict_quat(fn, ax, ay, az, aw, bx, by, bz, bw, ang);
    endtask

    function automatic comp_t rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return comp_t'($urandom_range(0, 16383)) - 16'sd8192;
            default: return comp_t'($urandom());
        endcase
    endfunction

    task automatic send_random(input logic [2:0] fn);
        send_request(fn, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                     rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                     16'($urandom()));
    endtask

    task automatic test_extremes();
        comp_t mx, mn, one;
        mx = 16'sh7fff; mn = -16'sh8000; one = 16'sd8192;
        send_request(FN_ADD, mx, mn, 0, one, mx, mn, 0, -one, 0);
        send_request(FN_SUB, mn, mx, -1, 0, mx, mn, 1, 0, 16'hffff);
        send_request(FN_MUL, mn, mn, mn, mn, mn, mn, mn, mn, 0);
        send_request(FN_MUL, 0, 0, 0, one, one, 0, 0, 0, 0);
        send_request(FN_MUL, mx, mx, mx, mx, mn, mx, mn, mx, 0);
        send_request(FN_MAT, 0, 0, 0, one, 0, 0, 0, 0, 0);
        send_request(FN_MAT, mn, mx, mn, mx, 0, 0, 0, 0, 0);
    endtask

    task automatic test_axis_angle();
        logic [15:0] angs[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
                                 16'hffff, 16'h0001, 16'h7fff, 16'h2000};
        foreach (angs[i])
            send_request(FN_AXIS, 16'sd8192, -16'sh8000, 16'sh7fff, 0, 0, 0, 0, 0, angs[i]);
    endtask

    task automatic test_unused_codes();
        for (int f = 5; f < 8; f++) send_random(3'(f));
        send_request(FN_ADD, 1, 2, 3, 4, 5, 6, 7, 8, 0);
    endtask

    task automatic test_random_ops();
        for (int n = 0; n < 340; n++) begin
            if ($urandom_range(0, 19) == 0) send_random(3'($urandom_range(5, 7)));
            else send_random(3'($urandom_range(0, 4)));
        end
    endtask

    // result side holds m_ready low for a randomly drawn wait before taking each result
    always @(posedge aclk) begin
        int w;
        if (!aresetn || (m_valid && m_ready))
            w = $urandom_range(0, 6);
        else if (m_valid && out_wait > 0)
            w = out_wait - 1;
        else
            w = out_wait;
        out_wait <= w;
        m_ready <= aresetn && (w == 0);
    end

    always @(posedge aclk) begin
        quat_row_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rows.size() == 0) begin
                $error("unexpected result row %0d", m_row_index);
                errors++;
            end else begin
                e = expected_rows.pop_front();
                if (m_res_x !== e.x) begin
                    $error("res_x exp %0d got %0d", e.x, m_res_x); errors++;
                end
                if (m_res_y !== e.y) begin
                    $error("res_y exp %0d got %0d", e.y, m_res_y); errors++;
                end
                if (m_res_z !== e.z) begin
                    $error("res_z exp %0d got %0d", e.z, m_res_z); errors++;
                end
                if (m_res_w !== e.w) begin
                    $error("res_w exp %0d got %0d", e.w, m_res_w); errors++;
                end
                if (m_row_index !== e.row) begin
                    $error("row_index exp %0d got %0d", e.row, m_row_index); errors++;
                end
                if (m_last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, m_last); errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("quaternion_arith_unit: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_axis_angle();
        test_unused_codes();
        test_random_ops();
        s_valid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge aclk);
        repeat (CORDIC_STEPS + 10) @(posedge aclk);
        if (errors == 0)
            $display("quaternion_arith_unit: match");
        else
            $display("quaternion_arith_unit: mismatch");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+src
src/qau_pkg.sv
src/qau_cell.sv
src/qau_finish.sv
src/quaternion_arith_unit.sv
tb/sv/tb_quaternion_arith_unit.sv
